/* src/keypad_calculator_engine_top_macros.svh */
// Assertion shorthands for the calculator engine checker.
`ifndef KEYPAD_CALCULATOR_ENGINE_TOP_MACROS_SVH
`define KEYPAD_CALCULATOR_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define KCE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kce: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define KCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kce: next-cycle check failed");

`endif

/* src/kce_pkg.sv */
`timescale 1ns / 1ps
package kce_pkg;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] upc_t;

	localparam logic [7:0] KEY_NONE  = 8'h00;
	localparam logic [7:0] KEY_0     = 8'h30;
	localparam logic [7:0] KEY_9     = 8'h39;
	localparam logic [7:0] KEY_PLUS  = 8'h2B;
	localparam logic [7:0] KEY_MINUS = 8'h2D;
	localparam logic [7:0] KEY_MUL   = 8'h2A;
	localparam logic [7:0] KEY_DIV   = 8'h2F;
	localparam logic [7:0] KEY_EQ    = 8'h3D;
	localparam logic [7:0] KEY_CLR   = 8'h43;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_FETCH,
		UOP_PRECLEAR,
		UOP_APPLY,
		UOP_LOAD,
		UOP_RES_SIMPLE,
		UOP_MUL_STEP,
		UOP_RES_MUL,
		UOP_DIV_STEP,
		UOP_RES_DIV,
		UOP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_NO_ITEM,
		CND_KEY_ZERO,
		CND_NOT_EQ,
		CND_OP_MUL,
		CND_OP_DIV,
		CND_MORE,
		CND_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic no_item;
		logic key_zero;
		logic key_not_eq;
		logic op_mul;
		logic op_div;
		logic more;
		logic out_free;
	} dp_status_t;

	localparam upc_t PC_WAIT   = 4'd0;
	localparam upc_t PC_GATE   = 4'd1;
	localparam upc_t PC_PRE    = 4'd2;
	localparam upc_t PC_APPLY  = 4'd3;
	localparam upc_t PC_LOAD   = 4'd4;
	localparam upc_t PC_CHKDIV = 4'd5;
	localparam upc_t PC_SIMPLE = 4'd6;
	localparam upc_t PC_MUL    = 4'd7;
	localparam upc_t PC_MULRES = 4'd8;
	localparam upc_t PC_DIV    = 4'd9;
	localparam upc_t PC_DIVRES = 4'd10;
	localparam upc_t PC_EMIT   = 4'd11;
	localparam upc_t PC_HOLD   = 4'd12;

	// microcode: taken jump goes to target, otherwise pc + 1
	function automatic uword_t urom(input upc_t pc);
		uword_t w;
		unique case (pc)
			PC_WAIT: begin
				w.uop = UOP_FETCH; w.cond = CND_NO_ITEM; w.target = PC_WAIT;
			end
			PC_GATE: begin
				w.uop = UOP_NOP; w.cond = CND_KEY_ZERO; w.target = PC_WAIT;
			end
			PC_PRE: begin
				w.uop = UOP_PRECLEAR; w.cond = CND_ALWAYS; w.target = PC_APPLY;
			end
			PC_APPLY: begin
				w.uop = UOP_APPLY; w.cond = CND_NOT_EQ; w.target = PC_EMIT;
			end
			PC_LOAD: begin
				w.uop = UOP_LOAD; w.cond = CND_OP_MUL; w.target = PC_MUL;
			end
			PC_CHKDIV: begin
				w.uop = UOP_NOP; w.cond = CND_OP_DIV; w.target = PC_DIV;
			end
			PC_SIMPLE: begin
				w.uop = UOP_RES_SIMPLE; w.cond = CND_ALWAYS; w.target = PC_EMIT;
			end
			PC_MUL: begin
				w.uop = UOP_MUL_STEP; w.cond = CND_MORE; w.target = PC_MUL;
			end
			PC_MULRES: begin
				w.uop = UOP_RES_MUL; w.cond = CND_ALWAYS; w.target = PC_EMIT;
			end
			PC_DIV: begin
				w.uop = UOP_DIV_STEP; w.cond = CND_MORE; w.target = PC_DIV;
			end
			PC_DIVRES: begin
				w.uop = UOP_RES_DIV; w.cond = CND_ALWAYS; w.target = PC_EMIT;
			end
			PC_EMIT: begin
				w.uop = UOP_EMIT; w.cond = CND_OUT_FREE; w.target = PC_WAIT;
			end
			PC_HOLD: begin
				w.uop = UOP_NOP; w.cond = CND_ALWAYS; w.target = PC_EMIT;
			end
			default: begin
				w.uop = UOP_NOP; w.cond = CND_ALWAYS; w.target = PC_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

/* src/kce_useq.sv */
`timescale 1ns / 1ps
module kce_useq import kce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output uop_t       uop
);

	upc_t   pc_q;
	uword_t uw;
	logic   take;

	always_comb begin
		uw = urom(pc_q);
	end

	always_comb begin
		unique case (uw.cond)
			CND_ALWAYS:   take = 1'b1;
			CND_NO_ITEM:  take = status.no_item;
			CND_KEY_ZERO: take = status.key_zero;
			CND_NOT_EQ:   take = status.key_not_eq;
			CND_OP_MUL:   take = status.op_mul;
			CND_OP_DIV:   take = status.op_div;
			CND_MORE:     take = status.more;
			CND_OUT_FREE: take = status.out_free;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= take ? uw.target : upc_t'(pc_q + 1'b1);
		end
	end

	assign uop = uw.uop;

endmodule

/* src/kce_datapath.sv */
`timescale 1ns / 1ps
module kce_datapath import kce_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  uop_t                    uop,
	output dp_status_t              status,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              key_code,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              echo_char,
	output logic                    clear_before,
	output logic                    clear_after,
	output logic                    result_valid,
	output logic signed [15:0]      result_value,
	output logic                    divide_by_zero
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(VALUE_WIDTH);

	// architectural state
	logic [W-1:0] first_q, second_q;
	op_t          op_q;
	logic         ent_q, fneg_q, sneg_q, shown_q;

	// per-item flags
	logic         clrb_q, clra_q, rvalid_q, dz_q, neg_q;

	// work registers
	logic [7:0]    key_q;
	logic [W-1:0]  x_q, y_q, z_q, r_q;
	logic [CW-1:0] cnt_q;

	logic          out_valid_q;
	logic [7:0]    out_echo_q;
	logic          out_clrb_q, out_clra_q, out_rv_q, out_dz_q;
	logic [15:0]   out_res_q;

	logic          key_digit, last, out_free, emitting, borrow;
	logic [W-1:0]  digit, acc_src, acc_next;
	logic [W-1:0]  va, vb, ma, mb, mul_sum, simple_res;
	logic [W:0]    trial;

	assign key_digit = (key_q >= KEY_0) && (key_q <= KEY_9);
	assign digit     = W'(key_q - KEY_0);
	assign acc_src   = ent_q ? second_q : first_q;
	assign acc_next  = (acc_src << 3) + (acc_src << 1) + digit;

	assign va = fneg_q ? -first_q : first_q;
	assign vb = sneg_q ? -second_q : second_q;
	assign ma = first_q[W-1] ? -first_q : first_q;
	assign mb = second_q[W-1] ? -second_q : second_q;

	assign mul_sum = z_q + (y_q[0] ? x_q : '0);
	assign trial   = {z_q, x_q[W-1]} - {1'b0, y_q};
	assign borrow  = trial[W];

	always_comb begin
		case (op_q)
			OP_ADD:  simple_res = va + vb;
			OP_SUB:  simple_res = va - vb;
			default: simple_res = '0;
		endcase
	end

	assign last     = (cnt_q == CW'(W - 1));
	assign out_free = !out_valid_q || out_ready;
	assign emitting = (uop == UOP_EMIT) && out_free;
	assign in_ready = (uop == UOP_FETCH);

	always_comb begin
		status.no_item    = !in_valid;
		status.key_zero   = (key_q == KEY_NONE);
		status.key_not_eq = (key_q != KEY_EQ);
		status.op_mul     = (op_q == OP_MUL);
		status.op_div     = (op_q == OP_DIV);
		status.more       = !last;
		status.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			op_q     <= OP_NONE;
			ent_q    <= 1'b0;
			fneg_q   <= 1'b0;
			sneg_q   <= 1'b0;
			shown_q  <= 1'b0;
			clrb_q   <= 1'b0;
			clra_q   <= 1'b0;
			rvalid_q <= 1'b0;
			dz_q     <= 1'b0;
			neg_q    <= 1'b0;
		end else begin
			unique case (uop)
				UOP_PRECLEAR: begin
					if (shown_q) begin
						first_q  <= '0;
						second_q <= '0;
						op_q     <= OP_NONE;
						ent_q    <= 1'b0;
						fneg_q   <= 1'b0;
						sneg_q   <= 1'b0;
						shown_q  <= 1'b0;
					end
					clrb_q   <= shown_q;
					clra_q   <= 1'b0;
					rvalid_q <= 1'b0;
					dz_q     <= 1'b0;
				end
				UOP_APPLY: begin
					if (key_digit) begin
						if (ent_q) begin
							second_q <= acc_next;
						end else begin
							first_q <= acc_next;
						end
					end else begin
						case (key_q)
							KEY_PLUS: begin
								if (first_q != '0 && op_q == OP_NONE) begin
									op_q  <= OP_ADD;
									ent_q <= 1'b1;
								end
							end
							KEY_MINUS: begin
								if (first_q != '0 && op_q == OP_NONE) begin
									op_q  <= OP_SUB;
									ent_q <= 1'b1;
								end else if (first_q == '0) begin
									fneg_q <= 1'b1;
								end else begin
									sneg_q <= 1'b1;
									ent_q  <= 1'b1;
								end
							end
							KEY_MUL: begin
								op_q  <= OP_MUL;
								ent_q <= 1'b1;
							end
							KEY_DIV: begin
								op_q  <= OP_DIV;
								ent_q <= 1'b1;
							end
							KEY_EQ: begin
								shown_q <= 1'b1;
							end
							KEY_CLR: begin
								first_q  <= '0;
								second_q <= '0;
								op_q     <= OP_NONE;
								ent_q    <= 1'b0;
								fneg_q   <= 1'b0;
								sneg_q   <= 1'b0;
								shown_q  <= 1'b0;
								clra_q   <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				UOP_LOAD: begin
					dz_q     <= (op_q == OP_DIV) && (second_q == '0);
					rvalid_q <= (op_q != OP_NONE);
					neg_q    <= first_q[W-1] ^ fneg_q ^ second_q[W-1] ^ sneg_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uop)
			UOP_FETCH: begin
				if (in_valid) begin
					key_q <= key_code;
				end
			end
			UOP_PRECLEAR: begin
				r_q <= '0;
			end
			UOP_LOAD: begin
				if (op_q == OP_MUL) begin
					x_q <= va;
					y_q <= vb;
				end else begin
					x_q <= ma;
					y_q <= mb;
				end
				z_q   <= '0;
				cnt_q <= '0;
			end
			UOP_MUL_STEP: begin
				z_q   <= mul_sum;
				x_q   <= x_q << 1;
				y_q   <= y_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			UOP_DIV_STEP: begin
				if (!borrow) begin
					z_q <= trial[W-1:0];
				end else begin
					z_q <= {z_q[W-2:0], x_q[W-1]};
				end
				x_q   <= {x_q[W-2:0], !borrow};
				cnt_q <= cnt_q + 1'b1;
			end
			UOP_RES_SIMPLE: begin
				r_q <= simple_res;
			end
			UOP_RES_MUL: begin
				r_q <= z_q;
			end
			UOP_RES_DIV: begin
				r_q <= dz_q ? '0 : (neg_q ? -x_q : x_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emitting) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emitting) begin
			out_echo_q <= key_q;
			out_clrb_q <= clrb_q;
			out_clra_q <= clra_q;
			out_rv_q   <= rvalid_q;
			out_dz_q   <= dz_q;
			out_res_q  <= 16'({{16{r_q[W-1]}}, r_q});
		end
	end

	assign out_valid      = out_valid_q;
	assign echo_char      = out_echo_q;
	assign clear_before   = out_clrb_q;
	assign clear_after    = out_clra_q;
	assign result_valid   = out_rv_q;
	assign result_value   = $signed(out_res_q);
	assign divide_by_zero = out_dz_q;

endmodule

/* src/keypad_calculator_engine_top.sv */
`timescale 1ns / 1ps
// channel   signals                        payload
// -------   ----------------------------   -------------------------------------
// in        in_valid / in_ready            key_code
// out       out_valid / out_ready          echo_char, clear_before, clear_after,
//                                          result_valid, result_value, divide_by_zero
//
// One item at a time, run by a 13-step microprogram. Key zero gives no output.
// Other keys go to the output register; '=' with add, subtract or no operation
// first loads and forms a simple result; multiply and divide loop over the bits
// (one bit per cycle through the shared x/y/z work registers). arst_n clears the
// sequencer, calculator state and out_valid only. A full output register loops
// the sequencer between its emit and hold steps; in_ready is high only at fetch.
module keypad_calculator_engine_top import kce_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         key_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         echo_char,
	output logic               clear_before,
	output logic               clear_after,
	output logic               result_valid,
	output logic signed [15:0] result_value,
	output logic               divide_by_zero
);

	uop_t       uop;
	dp_status_t status;

	kce_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uop    (uop)
	);

	kce_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.uop            (uop),
		.status         (status),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_code       (key_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.echo_char      (echo_char),
		.clear_before   (clear_before),
		.clear_after    (clear_after),
		.result_valid   (result_valid),
		.result_value   (result_value),
		.divide_by_zero (divide_by_zero)
	);

endmodule

/* src/kce_checker.sv */
`timescale 1ns / 1ps
`include "keypad_calculator_engine_top_macros.svh"
module kce_checker import kce_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         echo_char,
	input logic               clear_after,
	input logic               result_valid,
	input logic signed [15:0] result_value,
	input logic               divide_by_zero
);

	`KCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(echo_char))
	`KCE_ASSERT_NOW(a_dz_zero, out_valid && divide_by_zero, result_valid && result_value == 16'sd0)
	`KCE_ASSERT_NOW(a_novalid_zero, out_valid && !result_valid, result_value == 16'sd0)
	`KCE_ASSERT_NOW(a_result_eq, out_valid && result_valid, echo_char == KEY_EQ)
	`KCE_ASSERT_NOW(a_clear_key, out_valid && clear_after, echo_char == KEY_CLR)

endmodule

bind keypad_calculator_engine_top kce_checker u_kce_checker (.*);
